FILE: hw/rtl/gshare_tournament_branch_predictor_macros.svh
// ----------------------------------------------------------------------------
// gshare tournament branch predictor assertion macros
// concurrent assertion wrappers, empty when building for synthesis
// ----------------------------------------------------------------------------
`ifndef GSHARE_TOURNAMENT_BRANCH_PREDICTOR_MACROS_SVH
`define GSHARE_TOURNAMENT_BRANCH_PREDICTOR_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising edge, off while reset is asserted
`define GTBP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define GTBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define GTBP_ASSERT(lbl, clk, rst_n, prop, msg)
`define GTBP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: hw/rtl/gtbp_pkg.sv
// ----------------------------------------------------------------------------
// gtbp_pkg
// shared types, codes, sizes and helper functions of the branch predictor
// ----------------------------------------------------------------------------
`default_nettype none

package gtbp_pkg;

	// table geometry
	localparam int GHIST_MAX = 13;
	localparam int LHIST_MAX = 11;
	localparam int PC_MAX    = 11;

	localparam int GSIZE = 1 << GHIST_MAX;
	localparam int LSIZE = 1 << LHIST_MAX;
	localparam int PSIZE = 1 << PC_MAX;

	// clear counter spans the deepest table
	localparam int CLR_W_GL = (GHIST_MAX > LHIST_MAX) ? GHIST_MAX : LHIST_MAX;
	localparam int CLR_W    = (CLR_W_GL > PC_MAX) ? CLR_W_GL : PC_MAX;

	// configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_MODE  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GBITS = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LBITS = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PBITS = 8'd3;

	// predictor modes
	localparam logic [1:0] MODE_STATIC     = 2'd0;
	localparam logic [1:0] MODE_GSHARE     = 2'd1;
	localparam logic [1:0] MODE_TOURNAMENT = 2'd2;

	// register reset values
	localparam logic [1:0]            MODE_RST  = MODE_GSHARE;
	localparam logic [CFG_DATA_W-1:0] GBITS_RST = 4'd13;
	localparam logic [CFG_DATA_W-1:0] LBITS_RST = 4'd11;
	localparam logic [CFG_DATA_W-1:0] PBITS_RST = 4'd11;

	// item functions
	localparam logic FUNC_PREDICT = 1'b0;
	localparam logic FUNC_TRAIN   = 1'b1;

	// 2-bit saturating counter
	typedef logic [1:0] ctr_t;
	localparam ctr_t CTR_MIN  = 2'd0;
	localparam ctr_t CTR_WEAK = 2'd1;
	localparam ctr_t CTR_MAX  = 2'd3;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_EXEC
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clr_en;
		logic load_in;
		logic rd_a;
		logic rd_b;
		logic exec;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic out_full;
	} dp_status_t;

	// saturating step up or down
	function automatic ctr_t bump(input ctr_t ctr, input logic up);
		ctr_t res;
		if (up) begin
			res = (ctr == CTR_MAX) ? CTR_MAX : ctr + 2'd1;
		end else begin
			res = (ctr == CTR_MIN) ? CTR_MIN : ctr - 2'd1;
		end
		return res;
	endfunction

	// low-order ones, as many as bits says; wider counts give all ones
	function automatic logic [31:0] width_mask(input logic [CFG_DATA_W-1:0] bits);
		logic [31:0] m;
		for (int i = 0; i < 32; i++) begin
			m[i] = (int'(bits) > i);
		end
		return m;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gtbp_ctrl.sv
// ----------------------------------------------------------------------------
// gtbp_ctrl
// sequencer: table clear after reset, then accept, two reads, execute
// ----------------------------------------------------------------------------
`default_nettype none

`include "gshare_tournament_branch_predictor_macros.svh"

module gtbp_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  gtbp_pkg::dp_status_t    sts,
	output gtbp_pkg::ctrl_cmd_t     cmd
);
	import gtbp_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_ready    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
				if (in_valid) begin
					state_d = ST_RD_A;
				end
			end
			ST_RD_A: begin
				cmd.rd_a = 1'b1;
				state_d  = ST_RD_B;
			end
			ST_RD_B: begin
				cmd.rd_b = 1'b1;
				state_d  = ST_EXEC;
			end
			ST_EXEC: begin
				// hold while the previous result is still waiting
				if (!sts.out_full) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// sequencing checks
	`GTBP_ASSERT(a_accept_reads, clk, arst_n, (in_valid && in_ready) |=> (state_q == ST_RD_A), "accepted word did not start its reads")
	`GTBP_ASSERT(a_rd_b_exec, clk, arst_n, cmd.rd_b |=> (state_q == ST_EXEC), "second read not followed by execute")
	`GTBP_ASSERT(a_exec_room, clk, arst_n, cmd.exec |-> !sts.out_full, "execute while output register is occupied")
	`GTBP_ASSERT(a_exec_idle, clk, arst_n, cmd.exec |=> in_ready, "not ready after execute")

endmodule

`default_nettype wire

FILE: hw/rtl/gtbp_datapath.sv
// ----------------------------------------------------------------------------
// gtbp_datapath
// config registers, histories, counter tables and prediction/update logic
// ----------------------------------------------------------------------------
`default_nettype none

module gtbp_datapath (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  gtbp_pkg::ctrl_cmd_t                   cmd,
	output gtbp_pkg::dp_status_t                  sts,
	input  wire                                   func,
	input  wire  [31:0]                           pc,
	input  wire                                   outcome,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire  [gtbp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire  [gtbp_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic                                  predict_taken
);
	import gtbp_pkg::*;

	// configuration registers
	logic [1:0]            mode_q;
	logic [CFG_DATA_W-1:0] gbits_q;
	logic [CFG_DATA_W-1:0] lbits_q;
	logic [CFG_DATA_W-1:0] pbits_q;

	// captured input word
	logic        func_q;
	logic [31:0] pc_q;
	logic        outcome_q;

	logic [GHIST_MAX-1:0] ghist_q;
	logic [CLR_W-1:0]     clr_idx_q;
	logic                 out_valid_q;
	logic                 pred_q;

	// tables and their registered read data
	ctr_t                 gc_mem [GSIZE];
	ctr_t                 cc_mem [GSIZE];
	logic [LHIST_MAX-1:0] lh_mem [PSIZE];
	ctr_t                 lc_mem [LSIZE];

	ctr_t                 gc_rd_q;
	ctr_t                 cc_rd_q;
	logic [LHIST_MAX-1:0] lh_rd_q;
	ctr_t                 lc_rd_q;

	logic [GHIST_MAX-1:0] gmask;
	logic [LHIST_MAX-1:0] lmask;
	logic [PC_MAX-1:0]    pmask;
	logic [GHIST_MAX-1:0] g_idx;
	logic [GHIST_MAX-1:0] gs_idx;
	logic [GHIST_MAX-1:0] gc_idx;
	logic [PC_MAX-1:0]    p_idx;
	logic [LHIST_MAX-1:0] l_idx;

	logic is_gshare;
	logic is_tourn;
	logic do_train;
	logic g_pred;
	logic l_pred;
	logic g_ok;
	logic l_ok;
	logic pred;

	logic                 gc_we;
	logic [GHIST_MAX-1:0] gc_waddr;
	ctr_t                 gc_wdata;
	logic                 cc_we;
	logic [GHIST_MAX-1:0] cc_waddr;
	ctr_t                 cc_wdata;
	logic                 lh_we;
	logic [PC_MAX-1:0]    lh_waddr;
	logic [LHIST_MAX-1:0] lh_wdata;
	logic                 lc_we;
	logic [LHIST_MAX-1:0] lc_waddr;
	ctr_t                 lc_wdata;

	assign cfg_ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_RST;
			gbits_q <= GBITS_RST;
			lbits_q <= LBITS_RST;
			pbits_q <= PBITS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:  mode_q  <= cfg_data[1:0];
				REG_GBITS: gbits_q <= cfg_data;
				REG_LBITS: lbits_q <= cfg_data;
				REG_PBITS: pbits_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q    <= func;
			pc_q      <= pc;
			outcome_q <= outcome;
		end
	end

	// index generation
	assign gmask  = GHIST_MAX'(width_mask(gbits_q));
	assign lmask  = LHIST_MAX'(width_mask(lbits_q));
	assign pmask  = PC_MAX'(width_mask(pbits_q));
	assign g_idx  = ghist_q & gmask;
	assign gs_idx = (pc_q[GHIST_MAX-1:0] ^ ghist_q) & gmask;
	assign gc_idx = (mode_q == MODE_GSHARE) ? gs_idx : g_idx;
	assign p_idx  = pc_q[PC_MAX-1:0] & pmask;
	assign l_idx  = lh_rd_q & lmask;

	// prediction and training decisions
	assign is_gshare = (mode_q == MODE_GSHARE);
	assign is_tourn  = (mode_q == MODE_TOURNAMENT);
	assign do_train  = cmd.exec && (func_q == FUNC_TRAIN);
	assign g_pred    = gc_rd_q[1];
	assign l_pred    = lc_rd_q[1];
	assign g_ok      = (g_pred == outcome_q);
	assign l_ok      = (l_pred == outcome_q);

	always_comb begin
		if (is_gshare) begin
			pred = g_pred;
		end else if (is_tourn) begin
			pred = cc_rd_q[1] ? g_pred : l_pred;
		end else begin
			pred = 1'b1;
		end
	end

	// table write ports, the clear sweep takes priority
	assign gc_we    = cmd.clr_en || (do_train && (is_gshare || is_tourn));
	assign gc_waddr = cmd.clr_en ? clr_idx_q[GHIST_MAX-1:0] : gc_idx;
	assign gc_wdata = cmd.clr_en ? CTR_WEAK : bump(gc_rd_q, outcome_q);

	assign cc_we    = cmd.clr_en || (do_train && is_tourn && (g_ok != l_ok));
	assign cc_waddr = cmd.clr_en ? clr_idx_q[GHIST_MAX-1:0] : g_idx;
	assign cc_wdata = cmd.clr_en ? CTR_WEAK : bump(cc_rd_q, g_ok);

	assign lh_we    = cmd.clr_en || (do_train && is_tourn);
	assign lh_waddr = cmd.clr_en ? clr_idx_q[PC_MAX-1:0] : p_idx;
	assign lh_wdata = cmd.clr_en ? '0 : ((lh_rd_q << 1) | LHIST_MAX'(outcome_q));

	assign lc_we    = cmd.clr_en || (do_train && is_tourn);
	assign lc_waddr = cmd.clr_en ? clr_idx_q[LHIST_MAX-1:0] : l_idx;
	assign lc_wdata = cmd.clr_en ? CTR_WEAK : bump(lc_rd_q, outcome_q);

	// global counter table
	always_ff @(posedge clk) begin
		if (gc_we) begin
			gc_mem[gc_waddr] <= gc_wdata;
		end
		if (cmd.rd_a) begin
			gc_rd_q <= gc_mem[gc_idx];
		end
	end

	// choice counter table
	always_ff @(posedge clk) begin
		if (cc_we) begin
			cc_mem[cc_waddr] <= cc_wdata;
		end
		if (cmd.rd_a) begin
			cc_rd_q <= cc_mem[g_idx];
		end
	end

	// local history table
	always_ff @(posedge clk) begin
		if (lh_we) begin
			lh_mem[lh_waddr] <= lh_wdata;
		end
		if (cmd.rd_a) begin
			lh_rd_q <= lh_mem[p_idx];
		end
	end

	// local counter table, read once the local history is back
	always_ff @(posedge clk) begin
		if (lc_we) begin
			lc_mem[lc_waddr] <= lc_wdata;
		end
		if (cmd.rd_b) begin
			lc_rd_q <= lc_mem[l_idx];
		end
	end

	// global history and clear sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ghist_q   <= '0;
			clr_idx_q <= '0;
		end else begin
			if (do_train && (is_gshare || is_tourn)) begin
				ghist_q <= (ghist_q << 1) | GHIST_MAX'(outcome_q);
			end
			if (cmd.clr_en) begin
				clr_idx_q <= clr_idx_q + CLR_W'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec && (func_q == FUNC_PREDICT)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && (func_q == FUNC_PREDICT)) begin
			pred_q <= pred;
		end
	end

	assign out_valid     = out_valid_q;
	assign predict_taken = pred_q;

	assign sts.clr_last = &clr_idx_q;
	assign sts.out_full = out_valid_q && !out_ready;

endmodule

`default_nettype wire

FILE: hw/rtl/gshare_tournament_branch_predictor.sv
// ----------------------------------------------------------------------------
// gshare_tournament_branch_predictor
// conditional branch direction predictor: static, gshare or tournament mode
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_ready    func, pc[31:0], outcome
//  out      out_valid / out_ready  predict_taken
//  cfg      cfg_valid / cfg_ready  cfg_index[7:0], cfg_data[3:0]
//
//  each word goes through accept, table read, local counter read and execute;
//  the local counter read waits on the chained local history read
//  after reset a clear sweep fills the tables; no word is
//  accepted during it, config writes are taken at any time
//  a result still waiting at execute holds the sequencer there, and no new
//  word is taken until the output register frees up
// ----------------------------------------------------------------------------
`default_nettype none

module gshare_tournament_branch_predictor (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire                                   func,
	input  wire  [31:0]                           pc,
	input  wire                                   outcome,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic                                  predict_taken,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire  [gtbp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire  [gtbp_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import gtbp_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t sts;

	// sequencer
	gtbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// tables and datapath
	gtbp_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.func          (func),
		.pc            (pc),
		.outcome       (outcome),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.predict_taken (predict_taken)
	);

endmodule

`default_nettype wire
